/* rtl/core/upcf_pkg.sv */
// Package: constants, verdict codes and result type for the UDP port clone filter.
package upcf_pkg;

  localparam int unsigned OffsetWidth = 7;
  localparam int unsigned LenWidth    = OffsetWidth + 1;

  localparam logic [OffsetWidth-1:0] OffsetMax   = 7'd127;
  localparam logic [OffsetWidth-1:0] OffTypeHigh = 7'd12;
  localparam logic [OffsetWidth-1:0] OffTypeLow  = 7'd13;
  localparam logic [OffsetWidth-1:0] OffIhl      = 7'd14;
  localparam logic [OffsetWidth-1:0] OffProto    = 7'd23;

  localparam logic [OffsetWidth-1:0] EthHdrLen   = 7'd14;
  localparam logic [LenWidth-1:0]    EthIpHdrLen = 8'd34;
  localparam logic [LenWidth-1:0]    UdpHdrLen   = 8'd8;
  localparam logic [15:0]            EtherIpv4   = 16'h0800;
  localparam logic [7:0]             ProtoUdp    = 8'd17;

  localparam logic [7:0]  CloneCountReset = 8'd4;
  localparam logic [15:0] MatchPortReset  = 16'd8901;

  typedef enum logic [1:0] {
    CfgCloneCount = 2'd0,
    CfgMatchPort  = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    VerdictDrop  = 2'd0,
    VerdictPass  = 2'd1,
    VerdictClone = 2'd2
  } verdict_e;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] copies;
  } result_t;

endpackage

/* rtl/core/upcf_parse.sv */
// Header parser: per-frame state, field checks and verdict for one byte.
module upcf_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         frame_byte_i,
  input  logic               last_byte_i,
  input  logic               meta_present_i,
  input  logic [31:0]        meta_copy_i,
  input  logic [7:0]         clone_count_i,
  input  logic [15:0]        match_port_i,
  output upcf_pkg::result_t  result_o
);

  logic [upcf_pkg::OffsetWidth-1:0] byte_offset_q, byte_offset_d;
  logic                             meta_hit_q, meta_hit_d;
  logic [7:0]                       type_high_q, type_high_d;
  logic                             type_ok_q, type_ok_d;
  logic [3:0]                       header_words_q, header_words_d;
  logic                             proto_ok_q, proto_ok_d;
  logic [7:0]                       port_high_q, port_high_d;
  logic                             port_ok_q, port_ok_d;

  logic                             first;
  logic [upcf_pkg::OffsetWidth-1:0] udp_off;
  logic [upcf_pkg::LenWidth-1:0]    len;
  logic                             clone_hit;

  assign first   = (byte_offset_q == '0);
  assign udp_off = upcf_pkg::EthHdrLen + {1'b0, header_words_q, 2'b00};
  assign len     = {1'b0, byte_offset_q} + 8'd1;

  always_comb begin
    meta_hit_d     = first ? (meta_present_i && (meta_copy_i != 32'd0) &&
                              (meta_copy_i <= {24'd0, clone_count_i})) : meta_hit_q;
    type_high_d    = first ? 8'd0 : type_high_q;
    type_ok_d      = first ? 1'b0 : type_ok_q;
    header_words_d = first ? 4'd0 : header_words_q;
    proto_ok_d     = first ? 1'b0 : proto_ok_q;
    port_high_d    = first ? 8'd0 : port_high_q;
    port_ok_d      = first ? 1'b0 : port_ok_q;

    case (byte_offset_q)
      upcf_pkg::OffTypeHigh: type_high_d    = frame_byte_i;
      upcf_pkg::OffTypeLow:  type_ok_d      = ({type_high_q, frame_byte_i} ==
                                               upcf_pkg::EtherIpv4);
      upcf_pkg::OffIhl:      header_words_d = frame_byte_i[3:0];
      upcf_pkg::OffProto:    proto_ok_d     = (frame_byte_i == upcf_pkg::ProtoUdp);
      default: ;
    endcase

    if (byte_offset_q > upcf_pkg::EthHdrLen) begin
      if (byte_offset_q == udp_off + 7'd2) begin
        port_high_d = frame_byte_i;
      end else if (byte_offset_q == udp_off + 7'd3) begin
        port_ok_d = ({port_high_q, frame_byte_i} == match_port_i);
      end
    end

    if (last_byte_i) begin
      byte_offset_d = '0;
    end else if (byte_offset_q < upcf_pkg::OffsetMax) begin
      byte_offset_d = byte_offset_q + 7'd1;
    end else begin
      byte_offset_d = upcf_pkg::OffsetMax;
    end
  end

  assign clone_hit = type_ok_d && proto_ok_d && port_ok_d &&
                     (len >= upcf_pkg::EthIpHdrLen) &&
                     (len >= ({1'b0, udp_off} + upcf_pkg::UdpHdrLen));

  always_comb begin
    result_o.verdict = upcf_pkg::VerdictDrop;
    result_o.copies  = 8'd0;
    if (meta_hit_d) begin
      result_o.verdict = upcf_pkg::VerdictPass;
    end else if (clone_hit) begin
      result_o.verdict = upcf_pkg::VerdictClone;
      result_o.copies  = clone_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q  <= '0;
      meta_hit_q     <= 1'b0;
      type_high_q    <= 8'd0;
      type_ok_q      <= 1'b0;
      header_words_q <= 4'd0;
      proto_ok_q     <= 1'b0;
      port_high_q    <= 8'd0;
      port_ok_q      <= 1'b0;
    end else if (step_i) begin
      byte_offset_q  <= byte_offset_d;
      meta_hit_q     <= meta_hit_d;
      type_high_q    <= type_high_d;
      type_ok_q      <= type_ok_d;
      header_words_q <= header_words_d;
      proto_ok_q     <= proto_ok_d;
      port_high_q    <= port_high_d;
      port_ok_q      <= port_ok_d;
    end
  end

endmodule

/* rtl/core/udp_port_packet_clone_filter.sv */
// Top level: UDP port clone filter with input register, parser and result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o  | frame_byte_i, last_byte_i, meta_present_i,
//           |                          | meta_copy_i
//  out      | out_valid_o / out_ready_i| verdict_o, copies_o
//  cfg      | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One item per cycle unless a held result stalls a last byte.
// The input register feeds the parser, which updates frame state and loads the result register.
// A held result stalls only a last byte; other bytes keep flowing.
// Reset clears frame state and loads clone count 4 and match port 8901.
module udp_port_packet_clone_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  input  logic        meta_present_i,
  input  logic [31:0] meta_copy_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic [7:0]  copies_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [7:0]  clone_count_q;
  logic [15:0] match_port_q;

  logic        in_valid_q;
  logic [7:0]  frame_byte_q;
  logic        last_byte_q;
  logic        meta_present_q;
  logic [31:0] meta_copy_q;

  logic              out_valid_q;
  upcf_pkg::result_t result_q;
  upcf_pkg::result_t result_d;

  logic out_room;
  logic step;

  assign out_room   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (!last_byte_q || out_room);
  assign in_ready_o = !in_valid_q || step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clone_count_q <= upcf_pkg::CloneCountReset;
      match_port_q  <= upcf_pkg::MatchPortReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        upcf_pkg::CfgCloneCount: clone_count_q <= cfg_wdata_i[7:0];
        upcf_pkg::CfgMatchPort:  match_port_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_byte_q   <= frame_byte_i;
      last_byte_q    <= last_byte_i;
      meta_present_q <= meta_present_i;
      meta_copy_q    <= meta_copy_i;
    end
  end

  upcf_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .frame_byte_i   (frame_byte_q),
    .last_byte_i    (last_byte_q),
    .meta_present_i (meta_present_q),
    .meta_copy_i    (meta_copy_q),
    .clone_count_i  (clone_count_q),
    .match_port_i   (match_port_q),
    .result_o       (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= step && last_byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_byte_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = result_q.verdict;
  assign copies_o    = result_q.copies;

  a_copies_only_on_clone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.verdict != upcf_pkg::VerdictClone)) |-> (result_q.copies == 8'd0))
    else $error("copies set on a verdict other than clone");

  a_stalled_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(frame_byte_q) && $stable(last_byte_q)))
    else $error("stalled item lost from input register");

  a_last_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_byte_q) |-> out_room)
    else $error("verdict loaded over an untaken result");

endmodule
